@@ rtl/core/iff_pkg.sv @@
package iff_pkg;

    // saturation limit for width and precision
    localparam int MAX_FIELD_DEF = 48;

    localparam int VAL_W     = 32;
    localparam int NDIG      = 10;            // decimal digits of a 32-bit magnitude
    localparam int BCD_W     = 4 * NDIG;
    localparam int DD_STAGES = 4;             // double-dabble pipeline stages
    localparam int DD_BITS   = VAL_W / DD_STAGES;
    localparam int DCNT_W    = $clog2(NDIG + 1);

    // conversion kinds
    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;

    localparam logic [15:0][7:0] HEX_DIGITS = {
        8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
        8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
    };

    typedef struct packed {
        logic             opcode;
        logic [VAL_W-1:0] value;
        logic [5:0]       field_width;
        logic [5:0]       precision;
    } t_in_word;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } t_out_word;

    // one shift-and-add-3 step of binary to bcd conversion
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic b);
        logic [BCD_W-1:0] t;
        t = bcd;
        for (int k = 0; k < NDIG; k++) begin
            if (t[4*k +: 4] >= 4'd5) begin
                t[4*k +: 4] = t[4*k +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], b};
    endfunction

endpackage

@@ rtl/core/integer_field_formatter.sv @@
// integer field formatter: printf-style %d / %x with field width and precision
//
// input channel: i_valid / o_stall carry one i_word (opcode, value, field_width,
//   precision); a word is taken at a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carry one o_word per ascii character,
//   o_word.last marks the final character of a field
// order of characters: spaces up to the width, '-' for a negative decimal,
//   zeros up to the precision, then the digits; zero prints "0"
// width and precision above MAX_FIELD saturate to MAX_FIELD
// path: the first character reaches o_valid through the input stage, loaded on the
//   edge that takes the input word, then four double-dabble stages, the count stage,
//   the emitter and the output register
// throughput: one character per cycle while i_stall is low; a field holds the emitter
//   for each of its characters (1 to MAX_FIELD+1), fields follow with no gap,
//   and up to six more words wait in the pipeline behind it
// stall: i_stall holds the output register; the emitter and then each stage
//   stop in turn and o_stall rises once the pipeline is full; nothing is lost
// reset: synchronous, active low; clears all valid bits and the emitter
module integer_field_formatter
    import iff_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    // count width: enough for MAX_FIELD
    localparam int CW = $clog2(MAX_FIELD + 1);
    localparam logic [6:0]  MAXF7 = 7'(MAX_FIELD);
    localparam logic [CW-1:0] MAXF = CW'(MAX_FIELD);

    typedef struct packed {
        logic             hex;
        logic             neg;
        logic [VAL_W-1:0] mag;
        logic [CW-1:0]    width;
        logic [CW-1:0]    prec;
        logic [BCD_W-1:0] bcd;
    } t_stage;

    typedef struct packed {
        logic                    neg;
        logic [CW-1:0]           spc;
        logic [CW-1:0]           zro;
        logic [DCNT_W-1:0]       dcnt;
        logic [NDIG-1:0][3:0]    digs;
    } t_cnt;

    // conversion pipeline
    t_stage             r_st [DD_STAGES+1];
    t_stage             n_st [DD_STAGES+1];
    logic [DD_STAGES:0] r_vld;
    logic [DD_STAGES:0] st_rdy;

    // count stage
    t_cnt r_cs;
    t_cnt n_cs;
    logic r_cvld;
    logic c_rdy;

    // emitter
    logic                 r_busy;
    logic                 n_busy;
    logic                 r_neg;
    logic                 n_neg;
    logic [CW-1:0]        r_spc;
    logic [CW-1:0]        n_spc;
    logic [CW-1:0]        r_zro;
    logic [CW-1:0]        n_zro;
    logic [DCNT_W-1:0]    r_dcnt;
    logic [DCNT_W-1:0]    n_dcnt;
    logic [NDIG-1:0][3:0] r_digs;
    logic [NDIG-1:0][3:0] n_digs;
    logic                 emit_en;
    logic                 cur_last;
    logic                 em_rdy;
    logic                 em_load;
    logic [7:0]           cur_char;

    // output register
    logic      r_out_valid;
    t_out_word r_out;

    //------------------------------------------------------------------
    // handshake chain, from the output back to the input
    //------------------------------------------------------------------
    assign emit_en  = !r_out_valid || !i_stall;
    assign cur_last = (r_spc == '0) && !r_neg && (r_zro == '0) && (r_dcnt == DCNT_W'(1));
    // emitter takes a new field when idle or while sending the last digit
    assign em_rdy   = !r_busy || (emit_en && cur_last);
    assign em_load  = em_rdy && r_cvld;
    assign c_rdy    = !r_cvld || em_rdy;

    always_comb begin
        st_rdy[DD_STAGES] = !r_vld[DD_STAGES] || c_rdy;
        for (int k = DD_STAGES - 1; k >= 0; k--) begin
            st_rdy[k] = !r_vld[k] || st_rdy[k+1];
        end
    end

    assign o_stall = !st_rdy[0];

    //------------------------------------------------------------------
    // input stage: sign, magnitude, saturation
    //------------------------------------------------------------------
    always_comb begin
        n_st[0].hex   = (i_word.opcode == OP_HEX);
        n_st[0].neg   = (i_word.opcode == OP_DEC) && i_word.value[VAL_W-1];
        // two's complement negate also covers the most negative value
        n_st[0].mag   = n_st[0].neg ? (~i_word.value + VAL_W'(1)) : i_word.value;
        n_st[0].width = ({1'b0, i_word.field_width} > MAXF7) ? MAXF
                                                             : i_word.field_width[CW-1:0];
        n_st[0].prec  = ({1'b0, i_word.precision} > MAXF7) ? MAXF
                                                           : i_word.precision[CW-1:0];
        n_st[0].bcd   = '0;
    end

    //------------------------------------------------------------------
    // double-dabble stages, DD_BITS magnitude bits each, msb first
    //------------------------------------------------------------------
    for (genvar k = 1; k <= DD_STAGES; k++) begin : g_dd
        always_comb begin
            n_st[k] = r_st[k-1];
            for (int i = 0; i < DD_BITS; i++) begin
                n_st[k].bcd = dd_step(n_st[k].bcd,
                                      r_st[k-1].mag[VAL_W - 1 - DD_BITS*(k-1) - i]);
            end
        end
    end

    //------------------------------------------------------------------
    // count stage: digit count, zero and space padding
    //------------------------------------------------------------------
    always_comb begin
        logic [NDIG-1:0][3:0] digs;
        logic [DCNT_W-1:0]    nd;
        logic [CW:0]          nd_x;
        logic [CW:0]          prec_x;
        logic [CW:0]          width_x;
        logic [CW:0]          zro_x;
        logic [CW:0]          body;
        logic [CW:0]          spc_x;

        digs = r_st[DD_STAGES].hex ? {{(BCD_W-VAL_W){1'b0}}, r_st[DD_STAGES].mag}
                                   : r_st[DD_STAGES].bcd;
        nd = DCNT_W'(1);
        for (int k = 1; k < NDIG; k++) begin
            if (digs[k] != 4'd0) begin
                nd = DCNT_W'(k + 1);
            end
        end
        nd_x    = (CW+1)'(nd);
        prec_x  = {1'b0, r_st[DD_STAGES].prec};
        width_x = {1'b0, r_st[DD_STAGES].width};
        zro_x   = (prec_x > nd_x) ? (prec_x - nd_x) : '0;
        body    = zro_x + nd_x + (CW+1)'(r_st[DD_STAGES].neg);
        spc_x   = (width_x > body) ? (width_x - body) : '0;

        n_cs.neg  = r_st[DD_STAGES].neg;
        n_cs.spc  = spc_x[CW-1:0];
        n_cs.zro  = zro_x[CW-1:0];
        n_cs.dcnt = nd;
        n_cs.digs = digs;
    end

    //------------------------------------------------------------------
    // emitter: one character per cycle while the output is not stalled, region by region
    //------------------------------------------------------------------
    always_comb begin
        n_busy   = r_busy;
        n_neg    = r_neg;
        n_spc    = r_spc;
        n_zro    = r_zro;
        n_dcnt   = r_dcnt;
        n_digs   = r_digs;
        cur_char = HEX_DIGITS[r_digs[r_dcnt - DCNT_W'(1)]];

        if (r_spc != '0) begin
            cur_char = CHAR_SPACE;
        end else if (r_neg) begin
            cur_char = CHAR_MINUS;
        end else if (r_zro != '0) begin
            cur_char = CHAR_ZERO;
        end

        if (r_busy && emit_en) begin
            if (r_spc != '0) begin
                n_spc = r_spc - CW'(1);
            end else if (r_neg) begin
                n_neg = 1'b0;
            end else if (r_zro != '0) begin
                n_zro = r_zro - CW'(1);
            end else begin
                n_dcnt = r_dcnt - DCNT_W'(1);
                if (cur_last) begin
                    n_busy = 1'b0;
                end
            end
        end

        if (em_load) begin
            n_busy = 1'b1;
            n_neg  = r_cs.neg;
            n_spc  = r_cs.spc;
            n_zro  = r_cs.zro;
            n_dcnt = r_cs.dcnt;
            n_digs = r_cs.digs;
        end
    end

    //------------------------------------------------------------------
    // registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_cvld      <= 1'b0;
            r_busy      <= 1'b0;
            r_neg       <= 1'b0;
            r_spc       <= '0;
            r_zro       <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (st_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k <= DD_STAGES; k++) begin
                if (st_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (c_rdy) begin
                r_cvld <= r_vld[DD_STAGES];
            end
            r_busy <= n_busy;
            r_neg  <= n_neg;
            r_spc  <= n_spc;
            r_zro  <= n_zro;
            r_dcnt <= n_dcnt;
            if (emit_en) begin
                r_out_valid <= r_busy;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (st_rdy[0] && i_valid) begin
            r_st[0] <= n_st[0];
        end
        for (int k = 1; k <= DD_STAGES; k++) begin
            if (st_rdy[k] && r_vld[k-1]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (c_rdy && r_vld[DD_STAGES]) begin
            r_cs <= n_cs;
        end
        r_digs <= n_digs;
        if (emit_en && r_busy) begin
            r_out.char_out <= cur_char;
            r_out.last     <= cur_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    // a busy emitter always holds at least one digit, never more than NDIG
    a_dcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_dcnt != '0) && (r_dcnt <= DCNT_W'(NDIG)))
        else $error("emitter digit count out of range");

    // every field ends on a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.last) |->
            ((o_word.char_out >= CHAR_ZERO) && (o_word.char_out <= CHAR_NINE)) ||
            ((o_word.char_out >= CHAR_LC_A) && (o_word.char_out <= CHAR_LC_F)))
        else $error("field does not end on a digit");

    // emitter stays busy until the last character of its field is sent
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !(emit_en && cur_last)) |=> r_busy)
        else $error("emitter dropped a field early");

    // a character is sent only with an emitter that had a field
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_busy))
        else $error("output word without a field");

endmodule

@@ verif/integer_field_formatter_tb.sv @@
module integer_field_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iff_pkg::*;

    // saturation point of width and precision, as built into the dut
    localparam int FIELD_LIMIT = MAX_FIELD_DEF;
    // cycles to let pass after the last expected word, pipeline depth plus margin
    localparam int TAIL_CYCLES = 24;

    // expected text of every accepted field, one entry per output word
    class field_text_board;
        t_out_word expected_chars[$];
        int        errors;
        int        char_count;

        function new();
            errors     = 0;
            char_count = 0;
        endfunction

        // renders one field the way printf renders %<w>.<p>d or %<w>.<p>x
        function void add_field(t_in_word w);
            logic [31:0] mag;
            logic [3:0]  dval;
            logic [7:0]  digs[$];
            logic [7:0]  txt[$];
            logic        neg;
            int unsigned base;
            int unsigned wid;
            int unsigned prec;
            int unsigned zeros;
            int unsigned spaces;
            int unsigned body;
            t_out_word   c;

            wid  = (w.field_width > FIELD_LIMIT) ? FIELD_LIMIT : w.field_width;
            prec = (w.precision > FIELD_LIMIT) ? FIELD_LIMIT : w.precision;
            base = (w.opcode == OP_HEX) ? 16 : 10;

            // decimal takes the two's complement magnitude, the most negative value included
            neg = (w.opcode == OP_DEC) && w.value[31];
            mag = neg ? (32'd0 - w.value) : w.value;

            // digits come out least significant first; zero still yields one digit
            do begin
                dval = 4'(mag % base);
                digs.push_front((dval < 4'd10) ? (CHAR_ZERO + 8'(dval))
                                               : (CHAR_LC_A + 8'(dval - 4'd10)));
                mag = mag / base;
            end while (mag != 0);

            zeros  = (prec > digs.size()) ? prec - digs.size() : 0;
            body   = zeros + digs.size() + (neg ? 1 : 0);
            spaces = (wid > body) ? wid - body : 0;

            repeat (spaces) txt.push_back(CHAR_SPACE);
            if (neg) begin
                txt.push_back(CHAR_MINUS);
            end
            repeat (zeros) txt.push_back(CHAR_ZERO);
            foreach (digs[i]) txt.push_back(digs[i]);

            foreach (txt[i]) begin
                c.char_out = txt[i];
                c.last     = (i == txt.size() - 1);
                expected_chars.push_back(c);
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void check_char(t_out_word got);
            t_out_word want;
            char_count++;
            if (expected_chars.size() == 0) begin
                report($sformatf("char %0d: nothing expected, got %02h last %0b",
                                 char_count, got.char_out, got.last));
                return;
            end
            want = expected_chars.pop_front();
            if (got.char_out !== want.char_out) begin
                report($sformatf("char %0d: char_out expected %02h '%c', got %02h '%c'",
                                 char_count, want.char_out, want.char_out,
                                 got.char_out, got.char_out));
            end
            if (got.last !== want.last) begin
                report($sformatf("char %0d: last expected %0b, got %0b",
                                 char_count, want.last, got.last));
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_word  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_word;

    // both sides idle at random only while this is set
    logic      idle_on = 1'b0;

    field_text_board board;

    integer_field_formatter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard limit, far above the slowest legal run
    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_in_word pack_field(logic op, logic [31:0] val,
                                            logic [5:0] wid, logic [5:0] prec);
        t_in_word w;
        w.opcode      = op;
        w.value       = val;
        w.field_width = wid;
        w.precision   = prec;
        return w;
    endfunction

    // random field: values spread over magnitudes and signs, sizes mostly short
    function automatic t_in_word random_field();
        t_in_word w;
        w.opcode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: w.value = $urandom;
            1: w.value = $urandom_range(0, 999);
            2: w.value = 32'd0 - 32'($urandom_range(1, 999));
            3: w.value = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
            4: w.value = 32'h8000_0000 + 32'd0 - 32'($urandom_range(0, 3))
                         + 32'($urandom_range(0, 3));
            default: w.value = $urandom & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
        endcase
        // once in a while the full 6-bit range, saturation included
        w.field_width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 16));
        w.precision   = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 12));
        return w;
    endfunction

    // present one word and hold it until taken; valid stays high on return
    task automatic send_field(input t_in_word w);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 21) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_word  <= w;
        // o_stall read here is the value from before the edge
        do @(posedge i_clk); while (o_stall);
        board.add_field(w);
    endtask

    // drop valid and hold off until every expected word has come back
    task automatic drain_fields();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // output side: check each accepted word, then pick the next stall
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
                board.check_char(o_word);
            end
            i_stall <= idle_on && ($urandom_range(0, 99) < 21);
        end
    end

    initial begin
        t_in_word directed[$];

        board = new();

        directed.push_back(pack_field(OP_DEC, 32'd0, 6'd0, 6'd0));         // zero, bare
        directed.push_back(pack_field(OP_DEC, 32'd0, 6'd5, 6'd0));         // zero, padded
        directed.push_back(pack_field(OP_HEX, 32'd0, 6'd0, 6'd0));
        directed.push_back(pack_field(OP_DEC, 32'h8000_0000, 6'd0, 6'd0)); // most negative
        directed.push_back(pack_field(OP_DEC, 32'h8000_0000, 6'd20, 6'd15));
        directed.push_back(pack_field(OP_DEC, 32'h7fff_ffff, 6'd0, 6'd0));
        directed.push_back(pack_field(OP_DEC, 32'hffff_ffff, 6'd0, 6'd0)); // minus one
        directed.push_back(pack_field(OP_HEX, 32'hffff_ffff, 6'd0, 6'd0)); // hex has no sign
        directed.push_back(pack_field(OP_HEX, 32'h8000_0000, 6'd12, 6'd0));
        directed.push_back(pack_field(OP_DEC, 32'd12345, 6'd3, 6'd0));     // width too short
        directed.push_back(pack_field(OP_DEC, 32'd42, 6'd48, 6'd48));      // both at the limit
        directed.push_back(pack_field(OP_DEC, 32'hffff_ff85, 6'd63, 6'd63)); // longest field
        directed.push_back(pack_field(OP_HEX, 32'hdead_beef, 6'd63, 6'd0));
        directed.push_back(pack_field(OP_HEX, 32'h0123_abcd, 6'd0, 6'd63));
        directed.push_back(pack_field(OP_DEC, 32'd7, 6'd49, 6'd49));       // just above limit
        directed.push_back(pack_field(OP_HEX, 32'h0000_00a5, 6'd10, 6'd4));
        directed.push_back(pack_field(OP_DEC, 32'd0, 6'd0, 6'd63));        // zero with zeros
        directed.push_back(pack_field(OP_DEC, 32'd1_000_000_000, 6'd11, 6'd10));
        directed.push_back(pack_field(OP_DEC, 32'hffff_fffb, 6'd4, 6'd3)); // sign fills width
        directed.push_back(pack_field(OP_HEX, 32'h0000_0010, 6'd1, 6'd1));
        directed.push_back(pack_field(OP_HEX, 32'hfedc_ba98, 6'd32, 6'd16));
        directed.push_back(pack_field(OP_DEC, 32'd9, 6'd2, 6'd1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on <= 1'b1;

        foreach (directed[i]) send_field(directed[i]);

        for (int k = 0; k < 140; k++) begin
            // a long quiet stretch: neither side idles
            if (k == 40) begin
                idle_on <= 1'b0;
            end
            if (k == 90) begin
                idle_on <= 1'b1;
            end
            // let the pipeline run dry once mid-run
            if (k == 110) begin
                drain_fields();
            end
            send_field(random_field());
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        // anything arriving now has no expectation and is flagged by the checker
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
